// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

  // field widths on the stream ports
  localparam int KIND_W    = 1;
  localparam int REQ_W     = 13;
  localparam int ADDR_W    = 12;
  localparam int STATUS_W  = 3;
  localparam int TOTAL_W   = 13;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd4;

  // controller states
  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_SCAN    = 10'b00_0000_0100,
    S_HEAD    = 10'b00_0000_1000,
    S_MFIRST  = 10'b00_0001_0000,
    S_MERGE   = 10'b00_0010_0000,
    S_MEND    = 10'b00_0100_0000,
    S_RESTART = 10'b00_1000_0000,
    S_FREE    = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } ffa_state_t;

endpackage

// ===== rtl/ffa_mem.sv =====
module ffa_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 15,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_fit_arena_allocator_unit.sv =====
// flow: a zero size or bad address goes straight to the response; a free reads the
//   block header and then responds; an allocate walks the blocks and writes the granted
//   header; a failed walk runs a merge walk over the blocks, then a second walk
// handshake: one transaction at a time; the next is taken once the result is loaded into
//   the output register, and a result waiting on out_tready holds the input off
// reset: synchronous active-low; a clearing pass over every table entry
//   (512 at default sizes) runs before the first transaction is taken
module first_fit_arena_allocator_unit
  import ffa_pkg::*;
#(
  parameter int ARENA_BYTES  = 4096,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [12:0] request_size, [24:13] release_address
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [14:3] payload_address, [27:15] allocated_total
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // block starts are multiples of the largest power of two dividing align and header
  localparam int GMIX  = ALIGN_BYTES | HEADER_BYTES;
  localparam int GRAN  = GMIX & (-GMIX);
  localparam int GSH   = $clog2(GRAN);
  localparam int DEPTH = (ARENA_BYTES + GRAN - 1) / GRAN;
  localparam int IW    = $clog2(DEPTH);
  localparam int BW    = $clog2(ARENA_BYTES + 1);
  localparam int CW    = ((BW > REQ_W + 1) ? BW : (REQ_W + 1)) + 1;
  localparam int EW    = BW + 2;

  // size rounding by reciprocal multiplication, exact for sums below 2^(REQ_W+1)
  localparam int RND_SH = REQ_W + 1 + 7;
  localparam int MUL_W  = RND_SH + 1;
  localparam int PROD_W = REQ_W + 1 + MUL_W;
  localparam logic [MUL_W-1:0] RND_MUL =
    MUL_W'(((1 << RND_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES);

  localparam logic [CW-1:0] ARENA_C  = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HDR_C    = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] ALIGN_C  = CW'(ALIGN_BYTES);
  localparam logic [CW-1:0] GRAN_MASK = CW'(GRAN - 1);
  localparam logic [BW-1:0] INIT_BYTES = BW'(ARENA_BYTES - HEADER_BYTES);

  ffa_state_t state_r, state_nxt;

  logic [IW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] nxt_pos_r, nxt_pos_nxt;
  logic [BW-1:0] cur_bytes_r, cur_bytes_nxt;
  logic          cur_free_r, cur_free_nxt;
  logic          dirty_r, dirty_nxt;
  logic          merged_r, merged_nxt;
  logic [BW-1:0] in_use_r, in_use_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CW-1:0] res_payload_r, res_payload_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic [BW-1:0] rd_bytes;
  logic          rd_start;
  logic          rd_free;
  logic [CW-1:0] rd_bytes_c;
  logic [CW-1:0] scan_nxt;
  logic [CW-1:0] merge_nxt;
  logic [CW-1:0] tail;
  logic          fits;
  logic          split;
  logic [CW-1:0] req_c;
  logic [CW-1:0] addr_c;
  logic [CW-1:0] rel_pos;
  logic          addr_bad;
  logic [REQ_W:0]    rnd_sum;
  logic [PROD_W-1:0] rnd_prod;
  logic [REQ_W:0]    rnd_quo;
  logic [CW-1:0]     rnd_size;

  ffa_mem #(
    .DEPTH(DEPTH),
    .WIDTH(EW),
    .AW   (IW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // table entry fields and walk arithmetic
  assign rd_bytes   = rdata[EW-1:2];
  assign rd_start   = rdata[1];
  assign rd_free    = rdata[0];
  assign rd_bytes_c = CW'(rd_bytes);
  assign scan_nxt   = pos_r + HDR_C + rd_bytes_c;
  assign merge_nxt  = nxt_pos_r + HDR_C + rd_bytes_c;
  assign tail       = pos_r + HDR_C + size_r;
  assign fits       = rd_free && (rd_bytes_c >= size_r);
  assign split      = (rd_bytes_c >= size_r + HDR_C) && (tail < ARENA_C);

  // request decode
  assign req_c    = CW'(in_tdata[REQ_W-1:0]);
  assign addr_c   = CW'(in_tdata[REQ_W +: ADDR_W]);
  assign rel_pos  = addr_c - HDR_C;
  assign addr_bad = (addr_c < HDR_C) || (addr_c >= ARENA_C) || ((rel_pos & GRAN_MASK) != '0);

  // round the request up to the alignment
  assign rnd_sum  = {1'b0, in_tdata[REQ_W-1:0]} + (REQ_W+1)'(ALIGN_BYTES - 1);
  assign rnd_prod = PROD_W'(rnd_sum) * PROD_W'(RND_MUL);
  assign rnd_quo  = rnd_prod[RND_SH +: REQ_W+1];
  assign rnd_size = CW'(rnd_quo) * ALIGN_C;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // controller
  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    size_nxt        = size_r;
    pos_nxt         = pos_r;
    nxt_pos_nxt     = nxt_pos_r;
    cur_bytes_nxt   = cur_bytes_r;
    cur_free_nxt    = cur_free_r;
    dirty_nxt       = dirty_r;
    merged_nxt      = merged_r;
    in_use_nxt      = in_use_r;
    res_status_nxt  = res_status_r;
    res_payload_nxt = res_payload_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx_r;
        wdata = (clr_idx_r == '0) ? {INIT_BYTES, 1'b1, 1'b1} : '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          res_payload_nxt = '0;
          res_status_nxt  = ST_OK;
          merged_nxt      = 1'b0;
          if (in_tuser == KIND_ALLOC) begin
            if (req_c == '0) begin
              res_status_nxt = ST_ZERO;
              state_nxt      = S_RESP;
            end else begin
              size_nxt  = rnd_size;
              pos_nxt   = '0;
              raddr     = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (addr_bad) begin
              res_status_nxt = ST_BADADDR;
              state_nxt      = S_RESP;
            end else begin
              pos_nxt   = rel_pos;
              raddr     = IW'(rel_pos >> GSH);
              state_nxt = S_FREE;
            end
          end
        end
      end

      // first-fit walk, one block per cycle
      S_SCAN: begin
        if (fits) begin
          res_payload_nxt = pos_r + HDR_C;
          if (split) begin
            we    = 1'b1;
            waddr = IW'(tail >> GSH);
            wdata = {BW'(rd_bytes_c - size_r - HDR_C), 1'b1, 1'b1};
            cur_bytes_nxt = BW'(size_r);
            in_use_nxt    = BW'(CW'(in_use_r) + size_r + HDR_C);
          end else begin
            cur_bytes_nxt = rd_bytes;
            in_use_nxt    = BW'(CW'(in_use_r) + rd_bytes_c + HDR_C);
          end
          state_nxt = S_HEAD;
        end else if (scan_nxt >= ARENA_C) begin
          if (merged_r) begin
            res_status_nxt = ST_NOSPACE;
            state_nxt      = S_RESP;
          end else begin
            raddr     = '0;
            state_nxt = S_MFIRST;
          end
        end else begin
          pos_nxt = scan_nxt;
          raddr   = IW'(scan_nxt >> GSH);
        end
      end

      // granted block header, marked in use
      S_HEAD: begin
        we    = 1'b1;
        waddr = IW'(pos_r >> GSH);
        wdata = {cur_bytes_r, 1'b1, 1'b0};
        state_nxt = S_RESP;
      end

      // merge walk: load the first block
      S_MFIRST: begin
        pos_nxt       = '0;
        cur_bytes_nxt = rd_bytes;
        cur_free_nxt  = rd_free;
        dirty_nxt     = 1'b0;
        nxt_pos_nxt   = HDR_C + rd_bytes_c;
        if (HDR_C + rd_bytes_c >= ARENA_C) begin
          state_nxt = S_MEND;
        end else begin
          raddr     = IW'((HDR_C + rd_bytes_c) >> GSH);
          state_nxt = S_MERGE;
        end
      end

      // merge walk: absorb a free neighbor or move on
      S_MERGE: begin
        if (cur_free_r && rd_free) begin
          cur_bytes_nxt = BW'(CW'(cur_bytes_r) + HDR_C + rd_bytes_c);
          dirty_nxt     = 1'b1;
          we    = 1'b1;
          waddr = IW'(nxt_pos_r >> GSH);
          wdata = '0;
        end else begin
          if (dirty_r) begin
            we    = 1'b1;
            waddr = IW'(pos_r >> GSH);
            wdata = {cur_bytes_r, 1'b1, cur_free_r};
          end
          pos_nxt       = nxt_pos_r;
          cur_bytes_nxt = rd_bytes;
          cur_free_nxt  = rd_free;
          dirty_nxt     = 1'b0;
        end
        nxt_pos_nxt = merge_nxt;
        if (merge_nxt >= ARENA_C) begin
          state_nxt = S_MEND;
        end else begin
          raddr = IW'(merge_nxt >> GSH);
        end
      end

      S_MEND: begin
        if (dirty_r) begin
          we    = 1'b1;
          waddr = IW'(pos_r >> GSH);
          wdata = {cur_bytes_r, 1'b1, cur_free_r};
        end
        merged_nxt = 1'b1;
        state_nxt  = S_RESTART;
      end

      // second first-fit walk after the merge
      S_RESTART: begin
        pos_nxt   = '0;
        raddr     = '0;
        state_nxt = S_SCAN;
      end

      S_FREE: begin
        if (!rd_start) begin
          res_status_nxt = ST_BADADDR;
        end else if (rd_free) begin
          res_status_nxt = ST_FREED;
        end else begin
          we    = 1'b1;
          waddr = IW'(pos_r >> GSH);
          wdata = {rd_bytes, 1'b1, 1'b1};
          in_use_nxt = BW'(CW'(in_use_r) - rd_bytes_c - HDR_C);
        end
        state_nxt = S_RESP;
      end

      // load the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({CW'(in_use_r), res_payload_r[ADDR_W-1:0],
                                       res_status_r});
          out_data_nxt[OUT_DATA_W-1:STATUS_W+ADDR_W+TOTAL_W] = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      merged_r    <= 1'b0;
      dirty_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      merged_r    <= merged_nxt;
      dirty_r     <= dirty_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    size_r        <= size_nxt;
    pos_r         <= pos_nxt;
    nxt_pos_r     <= nxt_pos_nxt;
    cur_bytes_r   <= cur_bytes_nxt;
    cur_free_r    <= cur_free_nxt;
    res_status_r  <= res_status_nxt;
    res_payload_r <= res_payload_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule
